// File: design/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the symbol hash table core.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int KEY_W       = 48;
    localparam int VALUE_W     = 16;
    localparam int LINK_W      = 10;
    localparam int BKT_MAX_W   = 10;
    localparam int KEY_BYTES   = KEY_W / 8;
    localparam int KEY_CHARS   = 6;
    localparam int SUM_MAX     = 255 * KEY_CHARS;
    localparam int SUM_W       = $clog2(SUM_MAX + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_DEFINE = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       op;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        t_status                   status;
    } t_out_item;

    typedef struct packed {
        t_op                       op;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
        logic [BKT_MAX_W-1:0]      bucket;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
        logic [LINK_W-1:0]         next;
    } t_entry;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_RESULT
    } t_back_state;

endpackage

// File: design/symbol_hash_table_core.sv
// ----------------------------------------------------------------------------
// symbol_hash_table_core
// Chained hash table of short character keys: define and lookup engine.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_data): one transfer is one command,
// op define binds key to value, op lookup searches the key. Output channel
// (o_valid / i_stall / o_data): exactly one result transfer per command, in
// command order, with a status code and the value found by a lookup.
// The front takes one command, computes its bucket number by a reciprocal
// multiply in F_MOD and hands it to a two-entry queue in F_PUSH, where it
// waits while the queue is full; it accepts no new command until that push.
// The back pops a command in S_IDLE and reads the bucket head in S_HEAD; a
// define or a lookup of an empty bucket then goes to S_RESULT, and any other
// lookup walks the chain in S_WALK, one entry memory read per chain entry
// visited. With nothing waiting ahead, a command passes F_MOD, F_PUSH, the
// queue, S_IDLE, S_HEAD, its S_WALK steps and S_RESULT before its result is
// valid. The chain walk runs on the single read port of the entry memory.
// After reset the bucket head memory is cleared, one bucket per cycle; o_stall
// stays high until then. The output register holds a result while i_stall is
// high; the back then waits in S_RESULT with its next result, and the front
// keeps filling the queue until it is full, then o_stall stays high.
// ----------------------------------------------------------------------------
module symbol_hash_table_core #(
    parameter int POOL_ENTRIES = 512,
    parameter int BUCKETS      = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sht_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output sht_pkg::t_out_item o_data
);

    import sht_pkg::*;

    logic w_push, w_full, w_pop, w_empty, w_clearing;
    t_cmd w_push_data, w_pop_data;

    sht_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_hold      (w_clearing),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    sht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    sht_back #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .BUCKETS      (BUCKETS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_cmd      (w_pop_data),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule

// File: design/sht_ram.sv
// ----------------------------------------------------------------------------
// sht_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/sht_front.sv
// ----------------------------------------------------------------------------
// sht_front
// Accepts items, trims the key to its canonical form and reduces the
// character sum to a bucket number by reciprocal multiplication.
// ----------------------------------------------------------------------------
module sht_front #(
    parameter int BUCKETS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sht_pkg::t_in_item i_data,
    input  logic              i_hold,
    output logic              o_stall,
    output logic              o_push,
    output sht_pkg::t_cmd     o_push_data,
    input  logic              i_full
);

    import sht_pkg::*;

    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + BUCKETS - 1) / BUCKETS;

    t_front_state      r_state, n_state;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  r_quo, n_quo;
    t_cmd              r_cmd, n_cmd;

    logic [KEY_W-1:0]  w_key;
    logic [SUM_W-1:0]  w_sum;
    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_quo_b;
    logic [SUM_W-1:0]  w_rem;
    logic              w_accept;

    // canonical key and character sum
    always_comb begin
        logic       alive;
        logic [7:0] ch;
        alive = 1'b1;
        w_key = '0;
        w_sum = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            ch = i_data.key[8*i +: 8];
            if (alive && (i < KEY_CHARS) && (ch != 8'd0)) begin
                w_key[8*i +: 8] = ch;
                w_sum = w_sum + SUM_W'(ch);
            end else begin
                alive = 1'b0;
            end
        end
    end

    // quotient by reciprocal multiply, exact for sums up to SUM_MAX
    assign w_prod   = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign w_quo_b  = r_quo * SUM_W'(BUCKETS);
    assign w_rem    = r_sum - w_quo_b;
    assign o_stall  = (r_state != F_IDLE) || i_hold;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        o_push_data        = r_cmd;
        o_push_data.bucket = BKT_MAX_W'(w_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sum <= n_sum;
        r_quo <= n_quo;
        r_cmd <= n_cmd;
    end

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_quo   = r_quo;
        n_cmd   = r_cmd;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_cmd.op     = i_data.op;
                    n_cmd.key    = w_key;
                    n_cmd.value  = i_data.value;
                    n_cmd.bucket = '0;
                    n_sum        = w_sum;
                    n_state      = F_MOD;
                end
            end
            F_MOD: begin
                n_quo   = w_prod[RECIP_SHIFT +: SUM_W];
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

endmodule

// File: design/sht_queue.sv
// ----------------------------------------------------------------------------
// sht_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module sht_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sht_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output sht_pkg::t_cmd o_data,
    output logic          o_empty
);

    import sht_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/sht_back.sv
// ----------------------------------------------------------------------------
// sht_back
// Executes defines and lookups against the bucket head and entry memories
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module sht_back #(
    parameter int POOL_ENTRIES = 512,
    parameter int BUCKETS      = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  sht_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_valid,
    output sht_pkg::t_out_item o_data,
    input  logic               i_stall
);

    import sht_pkg::*;

    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    t_back_state       r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [LINK_W-1:0] r_steps, n_steps;
    logic [LINK_W-1:0] r_free, n_free;
    logic [BKT_W-1:0]  r_clr, n_clr;
    t_out_item         r_res, n_res;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              w_head_we, w_head_re;
    logic [BKT_W-1:0]  w_head_waddr, w_head_raddr;
    logic [LINK_W-1:0] w_head_wdata, w_head_rdata;
    logic              w_ent_we, w_ent_re;
    logic [IDX_W-1:0]  w_ent_waddr, w_ent_raddr;
    t_entry            w_ent_wdata, w_ent_rdata;

    logic [LINK_W-1:0] w_free_m1, w_head_m1, w_next_m1;
    logic              w_head_null, w_next_null, w_out_free;

    sht_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_head_we),
        .i_wr_addr (w_head_waddr),
        .i_wr_data (w_head_wdata),
        .i_rd_en   (w_head_re),
        .i_rd_addr (w_head_raddr),
        .o_rd_data (w_head_rdata)
    );

    sht_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (POOL_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ent_we),
        .i_wr_addr (w_ent_waddr),
        .i_wr_data (w_ent_wdata),
        .i_rd_en   (w_ent_re),
        .i_rd_addr (w_ent_raddr),
        .o_rd_data (w_ent_rdata)
    );

    assign w_free_m1   = r_free - LINK_W'(1);
    assign w_head_m1   = w_head_rdata - LINK_W'(1);
    assign w_next_m1   = w_ent_rdata.next - LINK_W'(1);
    assign w_head_null = (w_head_rdata == '0) || (w_head_rdata > LINK_W'(POOL_ENTRIES));
    assign w_next_null = (w_ent_rdata.next == '0)
                      || (w_ent_rdata.next > LINK_W'(POOL_ENTRIES));
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= LINK_W'(POOL_ENTRIES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_cmd   <= n_cmd;
        r_steps <= n_steps;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_steps      = r_steps;
        n_free       = r_free;
        n_clr        = r_clr;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_stall;
        o_pop        = 1'b0;
        w_head_we    = 1'b0;
        w_head_waddr = r_cmd.bucket[BKT_W-1:0];
        w_head_wdata = r_free;
        w_head_re    = 1'b0;
        w_head_raddr = i_cmd.bucket[BKT_W-1:0];
        w_ent_we     = 1'b0;
        w_ent_waddr  = w_free_m1[IDX_W-1:0];
        w_ent_wdata  = '{key: r_cmd.key, value: r_cmd.value, next: w_head_rdata};
        w_ent_re     = 1'b0;
        w_ent_raddr  = w_head_m1[IDX_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                w_head_we    = 1'b1;
                w_head_waddr = r_clr;
                w_head_wdata = '0;
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + BKT_W'(1);
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd;
                    w_head_re = 1'b1;
                    n_state   = S_HEAD;
                end
            end
            S_HEAD: begin
                n_res.result_value = '0;
                n_res.status       = ST_OK;
                if (r_cmd.op == OP_DEFINE) begin
                    if (r_free == '0) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_ent_we  = 1'b1;
                        w_head_we = 1'b1;
                        n_free    = w_free_m1;
                    end
                    n_state = S_RESULT;
                end else if (w_head_null) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state      = S_RESULT;
                end else begin
                    w_ent_re = 1'b1;
                    n_steps  = '0;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                if (w_ent_rdata.key == r_cmd.key) begin
                    n_res.result_value = w_ent_rdata.value;
                    n_res.status       = ST_OK;
                    n_state            = S_RESULT;
                end else if (w_next_null || (r_steps == LINK_W'(POOL_ENTRIES - 1))) begin
                    n_res.result_value = '0;
                    n_res.status       = ST_NOT_FOUND;
                    n_state            = S_RESULT;
                end else begin
                    w_ent_re    = 1'b1;
                    w_ent_raddr = w_next_m1[IDX_W-1:0];
                    n_steps     = r_steps + LINK_W'(1);
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: tb/symbol_hash_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_hash_table_core_tb
// Self-checking bench for the symbol hash table core. A directed table covers
// empty and full-width keys, padding after the key terminator, bucket
// collisions, redefinitions and lookups of unknown names. Random define and
// lookup traffic over a bank of colliding names then fills the entry pool and
// runs on into the pool-full case. Each result transfer is compared with the
// row's fixed expectation for directed rows marked fixed, else with a software
// copy of the table. Command gaps and result stalls are random.
module symbol_hash_table_core_tb;
    import sht_pkg::*;

    localparam int POOL_ENTRIES = 512;
    localparam int BUCKETS      = 64;
    localparam int BANK_SIZE    = 40;
    localparam int FULL_TAIL    = 10;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               fixed;
        logic [VALUE_W-1:0] exp_value;
        t_status            exp_status;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    // software copy of the table
    logic [LINK_W-1:0]  head_link [BUCKETS];
    logic [KEY_W-1:0]   slot_key  [POOL_ENTRIES];
    logic [VALUE_W-1:0] slot_value[POOL_ENTRIES];
    logic [LINK_W-1:0]  slot_next [POOL_ENTRIES];
    int                 free_slots;

    t_out_item        awaited_results[$];
    t_out_item        oldest;
    t_stim_row        stim_rows[$];
    logic [KEY_W-1:0] name_bank[BANK_SIZE];
    int               name_len[BANK_SIZE];
    int               quiet_items;

    int errors;
    int n_define;
    int n_full;
    int n_lookup;
    int n_hit;
    int n_miss;

    symbol_hash_table_core #(
        .POOL_ENTRIES(POOL_ENTRIES),
        .BUCKETS     (BUCKETS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw,
                                                  output int bucket);
        logic [KEY_W-1:0] kept;
        logic [7:0]       ch;
        int               sum;
        bit               ended;
        kept  = '0;
        sum   = 0;
        ended = 1'b0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            ch = raw[8*i +: 8];
            if (ch == 8'd0) ended = 1'b1;
            if (!ended) begin
                kept[8*i +: 8] = ch;
                sum += ch;
            end
        end
        bucket = sum % BUCKETS;
        return kept;
    endfunction

    function automatic t_out_item calc_symbol_result(input t_in_item it);
        t_out_item         res;
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] link;
        int                bucket;
        int                idx;
        int                steps;
        bit                found;
        res.result_value = '0;
        res.status       = ST_OK;
        key = trim_key(it.key, bucket);
        if (it.op == OP_DEFINE) begin
            if (free_slots == 0) begin
                res.status = ST_FULL;
            end else begin
                free_slots--;
                idx               = free_slots;
                slot_key[idx]     = key;
                slot_value[idx]   = it.value;
                slot_next[idx]    = head_link[bucket];
                head_link[bucket] = LINK_W'(idx + 1);
            end
        end else begin
            link  = head_link[bucket];
            steps = 0;
            found = 1'b0;
            while (!found && link != '0 && steps < POOL_ENTRIES) begin
                idx = int'(link) - 1;
                if (slot_key[idx] == key) begin
                    found            = 1'b1;
                    res.result_value = slot_value[idx];
                end else begin
                    link = slot_next[idx];
                end
                steps++;
            end
            if (!found) res.status = ST_NOT_FOUND;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_items > 0) begin
            quiet_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet_items = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic add_row(input t_op op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value, input logic fixed,
                           input logic [VALUE_W-1:0] exp_value, input t_status exp_status);
        t_stim_row row;
        row.op         = op;
        row.key        = key;
        row.value      = value;
        row.fixed      = fixed;
        row.exp_value  = exp_value;
        row.exp_status = exp_status;
        stim_rows.push_back(row);
    endtask

    task automatic send_item(input t_in_item it, input logic fixed,
                             input t_out_item fixed_res);
        int        gap;
        t_out_item res;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = calc_symbol_result(it);
        if (it.op == OP_DEFINE) begin
            n_define++;
            if (res.status == ST_FULL) n_full++;
        end else begin
            n_lookup++;
            if (res.status == ST_OK) n_hit++;
            else n_miss++;
        end
        if (fixed) res = fixed_res;
        awaited_results.push_back(res);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    initial begin : result_stalls
        int r;
        int run;
        int hold;
        i_stall <= 1'b0;
        repeat (8) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 8) run = $urandom_range(60, 200);
            else run = $urandom_range(0, 6);
            if (run > 0) begin
                i_stall <= 1'b0;
                repeat (run) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 80) hold = $urandom_range(1, 3);
            else if (r < 96) hold = $urandom_range(4, 12);
            else hold = $urandom_range(20, 60);
            i_stall <= 1'b1;
            repeat (hold) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: result transfer with none pending: value %0d status %0d",
                         $time, $signed(o_data.result_value), o_data.status);
            end else begin
                oldest = awaited_results.pop_front();
                if (o_data.result_value !== oldest.result_value) begin
                    errors++;
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             $signed(oldest.result_value), $signed(o_data.result_value));
                end
                if (o_data.status !== oldest.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             oldest.status, o_data.status);
                end
            end
        end
    end

    initial begin
        t_in_item    it;
        t_out_item   row_res;
        logic [63:0] r64;
        int          pick;
        int          slot;
        int          n;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        foreach (head_link[b]) head_link[b] = '0;
        free_slots = POOL_ENTRIES;

        // names over a small alphabet collide in buckets; every fourth is wide
        for (int b = 0; b < BANK_SIZE; b++) begin
            name_len[b]  = (b == 0) ? 0 : $urandom_range(1, KEY_CHARS);
            name_bank[b] = '0;
            for (int c = 0; c < name_len[b]; c++) begin
                if (b % 4 == 3) name_bank[b][8*c +: 8] = 8'($urandom_range(1, 255));
                else name_bank[b][8*c +: 8] = 8'($urandom_range(97, 100));
            end
        end

        add_row(OP_LOOKUP, 48'h0,              16'h0,    1'b1, 16'h0,    ST_NOT_FOUND);
        add_row(OP_LOOKUP, 48'h41,             16'h0,    1'b1, 16'h0,    ST_NOT_FOUND);
        add_row(OP_DEFINE, 48'h0,              16'h7FFF, 1'b1, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h0,              16'h0,    1'b1, 16'h7FFF, ST_OK);
        add_row(OP_LOOKUP, 48'hFFFF_FFFF_FF00, 16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_DEFINE, 48'hFFFF_FFFF_FFFF, 16'h8000, 1'b1, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 16'h0,    1'b1, 16'h8000, ST_OK);
        add_row(OP_DEFINE, 48'h4241,           16'h0001, 1'b1, 16'h0,    ST_OK);
        add_row(OP_DEFINE, 48'h4142,           16'h0002, 1'b1, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h4241,           16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h4142,           16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_DEFINE, 48'h4241,           16'hFFFF, 1'b1, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h4241,           16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'hFFFF_FF00_4241, 16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h43_4241,        16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h40,             16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_DEFINE, 48'h8000_0000_0001, 16'h0,    1'b1, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h01,             16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_DEFINE, 48'h40,             16'h1234, 1'b1, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h0,              16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h40,             16'h0,    1'b0, 16'h0,    ST_OK);
        add_row(OP_LOOKUP, 48'h4142,           16'hABCD, 1'b0, 16'h0,    ST_OK);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            it.op                = stim_rows[k].op;
            it.key               = stim_rows[k].key;
            it.value             = stim_rows[k].value;
            row_res.result_value = stim_rows[k].exp_value;
            row_res.status       = stim_rows[k].exp_status;
            send_item(it, stim_rows[k].fixed, row_res);
        end

        // mostly defines until the pool runs dry, then lookups and refused defines until FULL_TAIL are refused
        n = 0;
        while (n_full < FULL_TAIL) begin
            pick = $urandom_range(0, 99);
            if (pick < ((free_slots > 0) ? 5 : 50)) it.op = OP_LOOKUP;
            else it.op = OP_DEFINE;
            r64  = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < ((it.op == OP_DEFINE) ? 80 : 70)) begin
                slot   = $urandom_range(0, BANK_SIZE - 1);
                it.key = name_bank[slot];
                if (name_len[slot] < KEY_CHARS - 1 && $urandom_range(0, 3) == 0)
                    it.key |= KEY_W'(r64 << (8 * (name_len[slot] + 1)));
            end else begin
                it.key = r64[KEY_W-1:0];
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) it.value = 16'h8000;
            else if (pick == 1) it.value = 16'h7FFF;
            else it.value = VALUE_W'($urandom);
            if (n % 200 == 199) drain_results();
            send_item(it, 1'b0, '0);
            n++;
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        repeat (40) @(posedge i_clk);

        $display("covered %0d defines (%0d refused with the pool full) and %0d lookups",
                 n_define, n_full, n_lookup);
        $display("lookups found %0d keys and missed %0d; %0d mismatches",
                 n_hit, n_miss, errors);
        if (errors == 0) begin
            $display("symbol_hash_table_core_tb: clean");
        end else begin
            $display("symbol_hash_table_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("symbol_hash_table_core_tb: errors");
        $finish;
    end

endmodule

// File: files.f
design/sht_pkg.sv
design/sht_ram.sv
design/sht_front.sv
design/sht_queue.sv
design/sht_back.sv
design/symbol_hash_table_core.sv
tb/symbol_hash_table_core_tb.sv
